// ----- rtl/bthalloc_pkg.sv -----
// Shared constants, codes, types and helper functions for the heap allocator.
`timescale 1ns / 1ps
package bthalloc_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int ADDR_W     = 12;
    localparam int MEM_W      = 14;
    localparam int VAL_W      = 16;
    localparam int CNT_W      = 13;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [5:0]              op_t;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_NOOP  = 2'd3;

    // datapath operations
    localparam op_t OP_NONE      = 6'd0;
    localparam op_t OP_CLR       = 6'd1;
    localparam op_t OP_LATCH     = 6'd2;
    localparam op_t OP_A_INIT    = 6'd3;
    localparam op_t OP_WALK_RH   = 6'd4;
    localparam op_t OP_WALK_RN   = 6'd5;
    localparam op_t OP_WALK_LINK = 6'd6;
    localparam op_t OP_A_END     = 6'd7;
    localparam op_t OP_A_SPLIT   = 6'd8;
    localparam op_t OP_TK0       = 6'd9;
    localparam op_t OP_TK1       = 6'd10;
    localparam op_t OP_SF_PREP   = 6'd11;
    localparam op_t OP_SF0       = 6'd12;
    localparam op_t OP_SF1       = 6'd13;
    localparam op_t OP_SF2       = 6'd14;
    localparam op_t OP_SF3       = 6'd15;
    localparam op_t OP_SF4       = 6'd16;
    localparam op_t OP_U0        = 6'd17;
    localparam op_t OP_U1        = 6'd18;
    localparam op_t OP_U2        = 6'd19;
    localparam op_t OP_U3        = 6'd20;
    localparam op_t OP_F_RH      = 6'd21;
    localparam op_t OP_F_RF      = 6'd22;
    localparam op_t OP_F_CHK     = 6'd23;
    localparam op_t OP_F_LH      = 6'd24;
    localparam op_t OP_F_LDEC    = 6'd25;
    localparam op_t OP_F_RDLH    = 6'd26;
    localparam op_t OP_F_LSZ     = 6'd27;
    localparam op_t OP_F_RR      = 6'd28;
    localparam op_t OP_F_RDEC    = 6'd29;
    localparam op_t OP_F_RDRH    = 6'd30;
    localparam op_t OP_F_RSZ     = 6'd31;
    localparam op_t OP_F_FREE    = 6'd32;
    localparam op_t OP_LOAD_OUT  = 6'd33;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic bytes_zero;
        logic fi_zero;
        logic walk_ok;
        logic walk_brk;
        logic best_none;
        logic split;
        logic free_bad;
        logic rd_pos;
    } stat_t;

    function automatic val_t abs_v(input val_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic val_t sat_v(input val_t v);
        if (v > val_t'(HEAP_WORDS))
            return val_t'(HEAP_WORDS);
        else if (v < -val_t'(HEAP_WORDS))
            return -val_t'(HEAP_WORDS);
        else
            return v;
    endfunction

    function automatic logic in_rng(input val_t a);
        return (a >= 0) && (a < val_t'(HEAP_WORDS));
    endfunction

    // footer position as seen after the header at t was written with v
    function automatic val_t foot_addr(input val_t t, input val_t v);
        val_t s;
        s = in_rng(t) ? abs_v(sat_v(v)) : '0;
        return t + s - val_t'(1);
    endfunction

    function automatic logic [MEM_W-1:0] init_word(input logic [ADDR_W-1:0] a);
        if (a == ADDR_W'(0) || a == ADDR_W'(1) ||
            a == ADDR_W'(HEAP_WORDS-2) || a == ADDR_W'(HEAP_WORDS-1))
            return MEM_W'(-2);
        else if (a == ADDR_W'(2) || a == ADDR_W'(HEAP_WORDS-3))
            return MEM_W'(HEAP_WORDS-4);
        else
            return '0;
    endfunction

endpackage

// ----- rtl/bthalloc_dp.sv -----
// Datapath of the heap allocator: heap memory, working registers and result registers.
`timescale 1ns / 1ps
module bthalloc_dp import bthalloc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              req_type,
    input  logic [15:0]       alloc_bytes,
    input  logic [ADDR_W-1:0] free_index,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_wdata,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] payload_index,
    output logic [ADDR_W-1:0] granted_words
);

    logic [MEM_W-1:0] mem [HEAP_WORDS];
    logic [MEM_W-1:0] mem_q;
    logic             oob_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [11:0]       limit_reg;
    val_t              head_reg;
    logic              is_free_reg, bytes_zero_reg, fi_zero_reg, split_reg;
    val_t              ints_reg, p_reg, best_reg, bsz_reg, extra_reg;
    logic [CNT_W-1:0]  cnt_reg, steps_reg;
    val_t              blk_reg, pv_reg, nx_reg, tgt_reg, tw_reg, wv_reg;
    val_t              idx_reg, hv_reg, sz_reg, foot_reg, rh_reg, lh_reg;
    logic [1:0]        res_st_reg;
    logic [ADDR_W-1:0] res_pay_reg, res_gr_reg;
    logic [1:0]        st_reg;
    logic [ADDR_W-1:0] pay_reg, gr_reg;

    val_t             rdv, rd_abs, extra, wa, wd, wd_sat, rd_addr;
    logic             rd_en, we, fit, better;
    logic [CNT_W-1:0] cnt_inc;
    logic [16:0]      bytes_q;
    val_t             ints_calc;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [MEM_W-1:0]  mem_wd;

    assign rdv     = oob_reg ? '0 : {{(VAL_W-MEM_W){mem_q[MEM_W-1]}}, mem_q};
    assign rd_abs  = abs_v(rdv);
    assign fit     = (rdv > 0) && (rdv >= ints_reg);
    assign better  = (best_reg == '0) || (rdv < bsz_reg);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign extra   = bsz_reg - ints_reg;
    assign bytes_q = (17'(alloc_bytes) + 17'd3) >> 2;
    assign ints_calc = (val_t'(bytes_q) + val_t'(2) < val_t'(4)) ? val_t'(4)
                                                                 : val_t'(bytes_q) + val_t'(2);

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == '1);
        stat.is_free    = is_free_reg;
        stat.bytes_zero = bytes_zero_reg;
        stat.fi_zero    = fi_zero_reg;
        stat.walk_ok    = (p_reg > 0) && (p_reg < val_t'(HEAP_WORDS)) &&
                          (steps_reg < CNT_W'(HEAP_WORDS));
        stat.walk_brk   = (rdv <= 0) || (fit && (cnt_inc == {1'b0, limit_reg}));
        stat.best_none  = (best_reg == '0);
        stat.split      = split_reg;
        stat.free_bad   = !((idx_reg >= val_t'(2)) && (hv_reg < 0) &&
                            (foot_reg <= val_t'(HEAP_WORDS-3)) && (rdv == hv_reg));
        stat.rd_pos     = (rdv > 0);
    end

    // memory access selection per operation
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = '0;
        unique case (cmd.op)
            OP_WALK_RH:   begin rd_en = 1'b1; rd_addr = p_reg; end
            OP_WALK_RN:   begin rd_en = 1'b1; rd_addr = p_reg + val_t'(1); end
            OP_U0:        begin rd_en = 1'b1; rd_addr = blk_reg + val_t'(2); end
            OP_U1:        begin rd_en = 1'b1; rd_addr = blk_reg + val_t'(1); end
            OP_U2:
            begin
                we = (pv_reg != '0);
                wa = pv_reg + val_t'(1);
                wd = rdv;
            end
            OP_U3:
            begin
                we = (nx_reg != '0);
                wa = nx_reg + val_t'(2);
                wd = pv_reg;
            end
            OP_TK0:       begin we = 1'b1; wa = tgt_reg; wd = -tw_reg; end
            OP_TK1:       begin we = 1'b1; wa = foot_addr(tgt_reg, -tw_reg); wd = -tw_reg; end
            OP_SF0:       begin we = 1'b1; wa = tgt_reg; wd = wv_reg; end
            OP_SF1:       begin we = 1'b1; wa = foot_addr(tgt_reg, wv_reg); wd = wv_reg; end
            OP_SF2:       begin we = 1'b1; wa = tgt_reg + val_t'(1); wd = head_reg; end
            OP_SF3:       begin we = 1'b1; wa = tgt_reg + val_t'(2); wd = '0; end
            OP_SF4:
            begin
                we = (head_reg != '0);
                wa = head_reg + val_t'(2);
                wd = tgt_reg;
            end
            OP_F_RH:      begin rd_en = 1'b1; rd_addr = idx_reg; end
            OP_F_RF:      begin rd_en = 1'b1; rd_addr = idx_reg + rd_abs - val_t'(1); end
            OP_F_CHK:     begin rd_en = 1'b1; rd_addr = idx_reg - val_t'(1); end
            OP_F_LH:      begin rd_en = 1'b1; rd_addr = idx_reg - rd_abs; end
            OP_F_RDLH:    begin rd_en = 1'b1; rd_addr = lh_reg; end
            OP_F_RR:      begin rd_en = 1'b1; rd_addr = rh_reg; end
            OP_F_RDRH:    begin rd_en = 1'b1; rd_addr = rh_reg; end
            default:      begin end
        endcase
    end

    always_comb
    begin
        wd_sat = sat_v(wd);
        if (cmd.op == OP_CLR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = init_word(clr_cnt_reg);
        end
        else
        begin
            mem_we = we && in_rng(wa);
            mem_wa = wa[ADDR_W-1:0];
            mem_wd = wd_sat[MEM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q   <= mem[rd_addr[ADDR_W-1:0]];
            oob_reg <= !in_rng(rd_addr);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            limit_reg   <= 12'd20;
            head_reg    <= val_t'(2);
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.op == OP_CLR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (cmd.op == OP_SF4)
                head_reg <= tgt_reg;
            if (cmd.op == OP_U2 && pv_reg == '0)
                head_reg <= rdv;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                is_free_reg    <= req_type;
                bytes_zero_reg <= (alloc_bytes == '0);
                fi_zero_reg    <= (free_index == '0);
                ints_reg       <= ints_calc;
                idx_reg        <= val_t'(free_index) - val_t'(1);
                res_st_reg     <= ST_NOOP;
                res_pay_reg    <= '0;
                res_gr_reg     <= '0;
            end
            OP_A_INIT:
            begin
                p_reg     <= head_reg;
                best_reg  <= '0;
                bsz_reg   <= '0;
                cnt_reg   <= '0;
                steps_reg <= '0;
            end
            OP_WALK_RH:   steps_reg <= steps_reg + CNT_W'(1);
            OP_WALK_RN:
            begin
                if (fit)
                begin
                    cnt_reg <= cnt_inc;
                    if (better)
                    begin
                        best_reg <= p_reg;
                        bsz_reg  <= rdv;
                    end
                end
            end
            OP_WALK_LINK: p_reg <= rdv;
            OP_A_END:
            begin
                blk_reg <= best_reg;
                if (best_reg == '0)
                    res_st_reg <= ST_NOFIT;
            end
            OP_A_SPLIT:
            begin
                split_reg   <= (extra >= val_t'(4));
                tgt_reg     <= best_reg;
                tw_reg      <= (extra >= val_t'(4)) ? ints_reg : bsz_reg;
                extra_reg   <= extra;
                res_st_reg  <= ST_OK;
                res_pay_reg <= best_reg[ADDR_W-1:0] + ADDR_W'(1);
                res_gr_reg  <= (extra >= val_t'(4)) ? ints_reg[ADDR_W-1:0]
                                                    : bsz_reg[ADDR_W-1:0];
            end
            OP_SF_PREP:
            begin
                tgt_reg <= best_reg + ints_reg;
                wv_reg  <= extra_reg;
            end
            OP_U1:        pv_reg <= rdv;
            OP_U2:        nx_reg <= rdv;
            OP_F_RF:
            begin
                hv_reg   <= rdv;
                sz_reg   <= rd_abs;
                foot_reg <= idx_reg + rd_abs - val_t'(1);
                rh_reg   <= idx_reg + rd_abs;
            end
            OP_F_CHK:
            begin
                if (stat.free_bad)
                    res_st_reg <= ST_BAD;
            end
            OP_F_LH:      lh_reg  <= idx_reg - rd_abs;
            OP_F_LDEC:    blk_reg <= lh_reg;
            OP_F_LSZ:
            begin
                idx_reg <= lh_reg;
                sz_reg  <= sz_reg + rd_abs;
            end
            OP_F_RDEC:    blk_reg <= rh_reg;
            OP_F_RSZ:     sz_reg  <= sz_reg + rd_abs;
            OP_F_FREE:
            begin
                tgt_reg    <= idx_reg;
                wv_reg     <= sz_reg;
                res_st_reg <= ST_OK;
            end
            OP_LOAD_OUT:
            begin
                st_reg  <= res_st_reg;
                pay_reg <= res_pay_reg;
                gr_reg  <= res_gr_reg;
            end
            default:      begin end
        endcase
    end

    assign status        = st_reg;
    assign payload_index = pay_reg;
    assign granted_words = gr_reg;

endmodule

// ----- rtl/bthalloc_ctrl.sv -----
// Controller state machine of the heap allocator: sequences datapath operations.
`timescale 1ns / 1ps
module bthalloc_ctrl import bthalloc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [5:0] S_CLEAR   = 6'd0;
    localparam logic [5:0] S_IDLE    = 6'd1;
    localparam logic [5:0] S_DISP    = 6'd2;
    localparam logic [5:0] S_A_INIT  = 6'd3;
    localparam logic [5:0] S_WH      = 6'd4;
    localparam logic [5:0] S_WN      = 6'd5;
    localparam logic [5:0] S_WL      = 6'd6;
    localparam logic [5:0] S_A_END   = 6'd7;
    localparam logic [5:0] S_A_SPLIT = 6'd8;
    localparam logic [5:0] S_TK0     = 6'd9;
    localparam logic [5:0] S_TK1     = 6'd10;
    localparam logic [5:0] S_SF_PREP = 6'd11;
    localparam logic [5:0] S_SF0     = 6'd12;
    localparam logic [5:0] S_SF1     = 6'd13;
    localparam logic [5:0] S_SF2     = 6'd14;
    localparam logic [5:0] S_SF3     = 6'd15;
    localparam logic [5:0] S_SF4     = 6'd16;
    localparam logic [5:0] S_U0      = 6'd17;
    localparam logic [5:0] S_U1      = 6'd18;
    localparam logic [5:0] S_U2      = 6'd19;
    localparam logic [5:0] S_U3      = 6'd20;
    localparam logic [5:0] S_F_RH    = 6'd21;
    localparam logic [5:0] S_F_RF    = 6'd22;
    localparam logic [5:0] S_F_CHK   = 6'd23;
    localparam logic [5:0] S_F_LH    = 6'd24;
    localparam logic [5:0] S_F_LDEC  = 6'd25;
    localparam logic [5:0] S_F_RDLH  = 6'd26;
    localparam logic [5:0] S_F_LSZ   = 6'd27;
    localparam logic [5:0] S_F_RR    = 6'd28;
    localparam logic [5:0] S_F_RDEC  = 6'd29;
    localparam logic [5:0] S_F_RDRH  = 6'd30;
    localparam logic [5:0] S_F_RSZ   = 6'd31;
    localparam logic [5:0] S_F_FREE  = 6'd32;
    localparam logic [5:0] S_FIN     = 6'd33;

    logic [5:0] state_reg, state_next;
    logic [5:0] ret_reg, ret_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ov_next    = ov_reg && !out_ready;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_free)
                    state_next = stat.fi_zero ? S_FIN : S_F_RH;
                else
                    state_next = stat.bytes_zero ? S_FIN : S_A_INIT;
            end
            S_A_INIT:  begin cmd.op = OP_A_INIT; state_next = S_WH; end
            S_WH:
            begin
                if (stat.walk_ok)
                begin
                    cmd.op     = OP_WALK_RH;
                    state_next = S_WN;
                end
                else
                    state_next = S_A_END;
            end
            S_WN:
            begin
                cmd.op     = OP_WALK_RN;
                state_next = stat.walk_brk ? S_A_END : S_WL;
            end
            S_WL:      begin cmd.op = OP_WALK_LINK; state_next = S_WH; end
            S_A_END:
            begin
                cmd.op = OP_A_END;
                if (stat.best_none)
                    state_next = S_FIN;
                else
                begin
                    ret_next   = S_A_SPLIT;
                    state_next = S_U0;
                end
            end
            S_A_SPLIT: begin cmd.op = OP_A_SPLIT; state_next = S_TK0; end
            S_TK0:     begin cmd.op = OP_TK0; state_next = S_TK1; end
            S_TK1:
            begin
                cmd.op     = OP_TK1;
                state_next = stat.split ? S_SF_PREP : S_FIN;
            end
            S_SF_PREP: begin cmd.op = OP_SF_PREP; state_next = S_SF0; end
            S_SF0:     begin cmd.op = OP_SF0; state_next = S_SF1; end
            S_SF1:     begin cmd.op = OP_SF1; state_next = S_SF2; end
            S_SF2:     begin cmd.op = OP_SF2; state_next = S_SF3; end
            S_SF3:     begin cmd.op = OP_SF3; state_next = S_SF4; end
            S_SF4:     begin cmd.op = OP_SF4; state_next = S_FIN; end
            S_U0:      begin cmd.op = OP_U0; state_next = S_U1; end
            S_U1:      begin cmd.op = OP_U1; state_next = S_U2; end
            S_U2:      begin cmd.op = OP_U2; state_next = S_U3; end
            S_U3:      begin cmd.op = OP_U3; state_next = ret_reg; end
            S_F_RH:    begin cmd.op = OP_F_RH; state_next = S_F_RF; end
            S_F_RF:    begin cmd.op = OP_F_RF; state_next = S_F_CHK; end
            S_F_CHK:
            begin
                cmd.op     = OP_F_CHK;
                state_next = stat.free_bad ? S_FIN : S_F_LH;
            end
            S_F_LH:    begin cmd.op = OP_F_LH; state_next = S_F_LDEC; end
            S_F_LDEC:
            begin
                cmd.op = OP_F_LDEC;
                if (stat.rd_pos)
                begin
                    ret_next   = S_F_RDLH;
                    state_next = S_U0;
                end
                else
                    state_next = S_F_RR;
            end
            S_F_RDLH:  begin cmd.op = OP_F_RDLH; state_next = S_F_LSZ; end
            S_F_LSZ:   begin cmd.op = OP_F_LSZ; state_next = S_F_RR; end
            S_F_RR:    begin cmd.op = OP_F_RR; state_next = S_F_RDEC; end
            S_F_RDEC:
            begin
                cmd.op = OP_F_RDEC;
                if (stat.rd_pos)
                begin
                    ret_next   = S_F_RDRH;
                    state_next = S_U0;
                end
                else
                    state_next = S_F_FREE;
            end
            S_F_RDRH:  begin cmd.op = OP_F_RDRH; state_next = S_F_RSZ; end
            S_F_RSZ:   begin cmd.op = OP_F_RSZ; state_next = S_F_FREE; end
            S_F_FREE:  begin cmd.op = OP_F_FREE; state_next = S_SF0; end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = OP_LOAD_OUT;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input accepted during memory init");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISP))
        else $error("accepted item not dispatched");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside finish state");

    a_unlink_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U3) |->
            (ret_reg == S_A_SPLIT || ret_reg == S_F_RDLH || ret_reg == S_F_RDRH))
        else $error("unlink return target invalid");

endmodule

// ----- rtl/boundary_tag_heap_allocator_unit.sv -----
// Top level of the boundary-tag best-fit heap allocator.
`timescale 1ns / 1ps
// Steps, from the accepting edge to out_valid: a no-op goes straight to the result. An allocate
//   walks the free list with a header read, link read and link follow per entry walked, then, when
//   a block is granted, unlinks it and writes its tags, and writes the tags of a split remainder.
//   A free checks header and footer, unlinks and merges each free neighbor, then writes the tags.
// Throughput: one item at a time; the next item is taken in the cycle after the result is loaded,
//   and loading waits while the previous result is still held on the output.
// Reset: asynchronous, active low. After reset the block writes the initial sentinel and
//   free-block image into all 4096 words of the heap memory and accepts no item meanwhile.
module boundary_tag_heap_allocator_unit import bthalloc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [15:0]       alloc_bytes,
    input  logic [ADDR_W-1:0] free_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] payload_index,
    output logic [ADDR_W-1:0] granted_words,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    // Controller: walks the request through read, check, unlink and tag-write steps.
    bthalloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: heap RAM, free-list head, search limit and the result item register.
    bthalloc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .alloc_bytes   (alloc_bytes),
        .free_index    (free_index),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .payload_index (payload_index),
        .granted_words (granted_words)
    );

endmodule

// ----- verif/bthalloc_checker.sv -----
// Reply checker for the heap allocator: tracks the heap image, predicts replies, compares.
`timescale 1ns / 1ps
module bthalloc_checker import bthalloc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              req_type,
    input  logic [15:0]       alloc_bytes,
    input  logic [ADDR_W-1:0] free_index,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [ADDR_W-1:0] payload_index,
    input  logic [ADDR_W-1:0] granted_words,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    typedef struct {
        logic [1:0]        st;
        logic [ADDR_W-1:0] pay;
        logic [ADDR_W-1:0] gw;
    } reply_t;

    int          heap_img [HEAP_WORDS];
    int          list_head;
    logic [11:0] fit_limit;
    reply_t      reply_q [$];

    function automatic int rd(int i);
        if (i < 0 || i >= HEAP_WORDS)
            return 0;
        return heap_img[i];
    endfunction

    function automatic void wr(int i, int v);
        if (i < 0 || i >= HEAP_WORDS)
            return;
        if (v > HEAP_WORDS)
            v = HEAP_WORDS;
        if (v < -HEAP_WORDS)
            v = -HEAP_WORDS;
        heap_img[i] = v;
    endfunction

    function automatic int size_at(int i);
        int v;
        v = rd(i);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void unlink(int i);
        int pv;
        int nx;
        pv = rd(i + 2);
        nx = rd(i + 1);
        if (pv == 0)
            list_head = nx;
        else
            wr(pv + 1, nx);
        if (nx != 0)
            wr(nx + 2, pv);
    endfunction

    function automatic void mark_free(int i, int words);
        wr(i, words);
        wr(i + size_at(i) - 1, words);
        wr(i + 1, list_head);
        wr(i + 2, 0);
        if (list_head != 0)
            wr(list_head + 2, i);
        list_head = i;
    endfunction

    function automatic void mark_taken(int i, int words);
        wr(i, -words);
        wr(i + size_at(i) - 1, -words);
    endfunction

    function automatic reply_t predict_reply(logic rt, logic [15:0] bytes, logic [11:0] fi);
        reply_t r;
        int need, best, best_sz, cnt, steps, p, sz, extra, idx, hv, foot, lh, rh;
        r.st = ST_NOOP;
        r.pay = '0;
        r.gw = '0;
        if (!rt) begin
            if (bytes != 0) begin
                need = (int'(bytes) + 3) / 4 + 2;
                if (need < 4)
                    need = 4;
                best = 0;
                best_sz = 0;
                cnt = 0;
                steps = 0;
                p = list_head;
                while (p > 0 && p < HEAP_WORDS && steps < HEAP_WORDS) begin
                    steps++;
                    if (rd(p) <= 0)
                        break;
                    sz = size_at(p);
                    if (sz >= need) begin
                        if (best == 0 || sz < best_sz) begin
                            best_sz = sz;
                            best = p;
                        end
                        cnt++;
                        // a limit of zero never matches: walk the whole list
                        if (cnt == int'(fit_limit))
                            break;
                    end
                    p = rd(p + 1);
                end
                if (best != 0) begin
                    extra = best_sz - need;
                    unlink(best);
                    if (extra >= 4) begin
                        mark_taken(best, need);
                        mark_free(best + need, extra);
                        r.gw = ADDR_W'(need);
                    end
                    else begin
                        mark_taken(best, best_sz);
                        r.gw = ADDR_W'(best_sz);
                    end
                    r.st = ST_OK;
                    r.pay = ADDR_W'(best + 1);
                end
                else
                    r.st = ST_NOFIT;
            end
        end
        else if (fi != 0) begin
            idx = int'(fi) - 1;
            hv = rd(idx);
            sz = (hv < 0) ? -hv : hv;
            foot = idx + sz - 1;
            r.st = ST_BAD;
            if (idx >= 2 && hv < 0 && foot <= HEAP_WORDS - 3 && rd(foot) == hv) begin
                lh = (idx - 1) - size_at(idx - 1) + 1;
                rh = idx + sz;
                if (rd(lh) > 0) begin
                    unlink(lh);
                    idx = lh;
                    sz += size_at(lh);
                end
                if (rd(rh) > 0) begin
                    unlink(rh);
                    sz += size_at(rh);
                end
                mark_free(idx, sz);
                r.st = ST_OK;
            end
        end
        return r;
    endfunction

    initial
    begin
        for (int k = 0; k < HEAP_WORDS; k++)
            heap_img[k] = 0;
        list_head = 0;
        fit_limit = 12'd20;
        mark_taken(0, 2);
        mark_free(2, HEAP_WORDS - 4);
        mark_taken(HEAP_WORDS - 2, 2);
        fail_count = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n) begin
            if (cfg_we)
                fit_limit = cfg_wdata;
            if (out_valid && out_ready) begin
                checked++;
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected reply st=%0d pay=%0d gw=%0d", $realtime,
                                 status, payload_index, granted_words);
                end
                else begin
                    exp_r = reply_q.pop_front();
                    if (status !== exp_r.st || payload_index !== exp_r.pay ||
                        granted_words !== exp_r.gw) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp st=%0d pay=%0d gw=%0d,",
                                      " got st=%0d pay=%0d gw=%0d"},
                                     $realtime, exp_r.st, exp_r.pay, exp_r.gw,
                                     status, payload_index, granted_words);
                    end
                end
            end
            if (in_valid && in_ready)
                reply_q.push_back(predict_reply(req_type, alloc_bytes, free_index));
            pending = reply_q.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the heap allocator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import bthalloc_pkg::*;

    localparam int STALL_LIMIT = 20000;   // idle cycles before giving up
    localparam int HOLD_CYCLES = 300;     // length of the long output hold-off

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [15:0]       alloc_bytes;
    logic [ADDR_W-1:0] free_index;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_index;
    logic [ADDR_W-1:0] granted_words;
    logic              cfg_we;
    logic [11:0]       cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    // idle odds in percent for each side
    int snd_idle;
    int rcv_idle;
    // hold-off request: the receiver process acts whenever the two differ
    int hold_req;
    int hold_seen;
    int hold_left;
    int quiet_cycles;
    int n_alloc;
    int n_free;

    // payload indexes that came back from good allocations, candidates for freeing
    logic [ADDR_W-1:0] live_blocks [$];

    boundary_tag_heap_allocator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .alloc_bytes  (alloc_bytes),
        .free_index   (free_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .payload_index(payload_index),
        .granted_words(granted_words),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    bthalloc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .alloc_bytes  (alloc_bytes),
        .free_index   (free_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .payload_index(payload_index),
        .granted_words(granted_words),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Receiver: drop ready at random, or for a long stretch when asked.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen) begin
            out_ready <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Remember granted blocks so that later frees hit real allocations.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_OK && granted_words != 0)
            live_blocks.push_back(payload_index);
    end

    // Watchdog: count cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic rt, input logic [15:0] bytes, input logic [11:0] fi);
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        alloc_bytes <= bytes;
        free_index  <= fi;
        if (rt)
            n_free++;
        else
            n_alloc++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every reply has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Write the search limit while the block is idle.
    task automatic set_limit(input logic [11:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Free a block returned earlier, chosen at random.
    task automatic free_live();
        int k;
        logic [11:0] p;
        k = $urandom_range(live_blocks.size() - 1);
        p = live_blocks[k];
        live_blocks.delete(k);
        send_item(1'b1, 16'd0, p);
    endtask

    // Directed item: send it alone and wait for its reply.
    task automatic one(input logic rt, input logic [15:0] bytes, input logic [11:0] fi);
        send_item(rt, bytes, fi);
        drain();
    endtask

    task automatic random_item();
        int pick;
        int free_odds;
        pick = $urandom_range(99);
        // free more often as the heap fills
        free_odds = (live_blocks.size() > 40) ? 70 : 42;
        if (pick < 4)
            send_item(1'b0, 16'd0, 12'($urandom));
        else if (pick < 6)
            send_item(1'b1, 16'($urandom), 12'd0);
        else if (pick < 13)
            send_item(1'b1, 16'($urandom), 12'($urandom));
        else if (live_blocks.size() > 0 && $urandom_range(99) < free_odds)
            free_live();
        else begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_item(1'b0, 16'($urandom_range(1, 120)), 12'($urandom));
            else if (pick < 95)
                send_item(1'b0, 16'($urandom_range(1, 2500)), 12'($urandom));
            else
                send_item(1'b0, 16'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = 1'b0;
        alloc_bytes = '0;
        free_index  = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        snd_idle    = 0;
        rcv_idle    = 0;
        hold_req    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        quiet_cycles = 0;
        n_alloc     = 0;
        n_free      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the widest search limit.
        set_limit(12'd4095);
        one(1'b0, 16'd0, 12'hFFF);        // zero-byte allocate is a no-op
        one(1'b1, 16'hFFFF, 12'd0);       // null free is a no-op
        one(1'b0, 16'hFFFF, 12'd0);       // oversize: nothing fits
        one(1'b0, 16'd16360, 12'd0);      // takes the whole free block exactly
        one(1'b0, 16'd1, 12'd0);          // heap empty now: no fit
        free_live();
        drain();
        one(1'b0, 16'd16352, 12'd0);      // remainder too small to split
        free_live();
        drain();
        one(1'b0, 16'd16000, 12'd0);      // large with a split remainder
        free_live();
        drain();
        one(1'b1, 16'd0, 12'hFFF);        // header on the high sentinel
        one(1'b1, 16'd0, 12'd1);          // header below the low bound
        one(1'b1, 16'd0, 12'd3);          // header is a free block
        // three neighbours, then free the outer ones and the middle to merge both sides
        one(1'b0, 16'd1, 12'd0);
        one(1'b0, 16'd8, 12'd0);
        one(1'b0, 16'd20, 12'd0);
        one(1'b1, 16'd0, live_blocks[0]);
        one(1'b1, 16'd0, live_blocks[2]);
        one(1'b1, 16'd0, live_blocks[1]);
        one(1'b1, 16'd0, live_blocks[1]); // double free is refused
        live_blocks.delete();
        one(1'b1, 16'd0, 12'd5);          // index inside a free region

        // Random part in three idling phases and several search limits.
        set_limit(12'd1);
        snd_idle = 30;
        rcv_idle = 61;
        for (int i = 0; i < 140; i++)
            random_item();
        set_limit(12'd0);
        for (int i = 0; i < 140; i++)
            random_item();
        set_limit(12'd3);
        snd_idle = 61;
        rcv_idle = 30;
        for (int i = 0; i < 280; i++)
            random_item();
        set_limit(12'd20);
        snd_idle = 0;
        rcv_idle = 0;
        for (int i = 0; i < 290; i++) begin
            if (i == 60)
                hold_req++;           // long hold-off while items keep coming
            random_item();
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Covered %0d allocates and %0d frees, %0d replies checked,", n_alloc, n_free,
                 checked);
        $display("search limits 0, 1, 3, 20 and 4095, with idling on both sides and a long stall.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- boundary_tag_heap_allocator_unit.f -----
rtl/bthalloc_pkg.sv
rtl/bthalloc_dp.sv
rtl/bthalloc_ctrl.sv
rtl/boundary_tag_heap_allocator_unit.sv
verif/bthalloc_checker.sv
verif/testbench.sv
